// ===== rtl/hfc_pkg.sv =====
package hfc_pkg;

   localparam int MAX_LIST_VERTICES = 16;
   localparam int PLANE_COUNT       = 6;
   localparam int FRAC_BITS         = 16;
   localparam int ATTRS             = 10;
   localparam int MAX_OUT           = 9;
   localparam int WORD_W            = 32;

   localparam int IDX_W   = $clog2(MAX_LIST_VERTICES);
   localparam int CNT_W   = $clog2(MAX_LIST_VERTICES + 1);
   localparam int ATTR_W  = $clog2(ATTRS);
   localparam int PLANE_W = $clog2(PLANE_COUNT);
   localparam int OUT_W   = $clog2(MAX_OUT + 1);

   // boundary values, their difference, and the quotient
   localparam int BND_W = WORD_W + 2;
   localparam int DIV_W = BND_W + 1;
   localparam int TQ_W  = FRAC_BITS + 1;
   localparam int PROD_W = WORD_W + 1 + TQ_W + 1;

   typedef logic [ATTRS-1:0][WORD_W-1:0] vert_type;

   // axis of each plane (0 = x, 1 = y, 2 = z) and whether the coordinate is subtracted
   localparam logic [1:0] PLANE_AXIS [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic       PLANE_NEG  [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   localparam int W_ATTR = 3;

   // w +/- coordinate, exact
   function automatic logic signed [BND_W-1:0] boundary(input vert_type v,
                                                        input logic [PLANE_W-1:0] plane);
      logic signed [BND_W-1:0] w;
      logic signed [BND_W-1:0] c;
      w = BND_W'($signed(v[W_ATTR]));
      c = BND_W'($signed(v[PLANE_AXIS[plane]]));
      return PLANE_NEG[plane] ? (w - c) : (w + c);
   endfunction

endpackage

// ===== rtl/hfc_div.sv =====
module hfc_div
   import hfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [TQ_W-1:0]  quot
);

   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W:0]    rem_ff;
   logic [DIV_W-1:0]  den_ff;
   logic [TQ_W-1:0]   quot_ff;
   logic [DIV_W:0]    rem_sh;
   logic              take;

   // one quotient bit a cycle by restoring subtraction
   always_comb begin
      rem_sh = {rem_ff[DIV_W-1:0], 1'b0};
      take   = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff <= den;
            rem_ff <= {1'b0, num};
            quot_ff <= '0;
            if (den == '0) begin
               done_ff <= 1'b1;
            end else if (num >= den) begin
               quot_ff <= TQ_W'(1) << FRAC_BITS;
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               step_ff <= STEP_W'(FRAC_BITS);
            end
         end else if (busy_ff) begin
            rem_ff  <= take ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            quot_ff <= {quot_ff[TQ_W-2:0], take};
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/homogeneous_frustum_polygon_clipper.sv =====
// Channel   Direction  Payload
// req_      in         tdata: pos_x,y,z,w, color_r,g,b,a, tex_s,t; tlast: last_vertex
// rsp_      out        tdata: out_x,y,z,w, out_r,g,b,a, out_s,t; tlast: end_of_polygon
//
// A vertex is taken in one cycle while the polygon is being collected.
// The request with tlast set starts the clip: six passes over registered-read
// vertex lists; each crossing runs the 16-step divider, then one shared
// multiplier pass over ten attributes.
// Results leave one at a time, the next read only after the last is taken; no request is taken during clip or output.
// Synchronous reset empties both lists; rsp_tvalid holds until rsp_tready.
module homogeneous_frustum_polygon_clipper
   import hfc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ATTRS*WORD_W-1:0] req_tdata,  // pos_x,pos_y,pos_z,pos_w,color_r,g,b,a,tex_s,tex_t
   input  logic                    req_tlast,  // last_vertex
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [ATTRS*WORD_W-1:0] rsp_tdata,  // out_x,out_y,out_z,out_w,out_r,g,b,a,out_s,out_t
   output logic                    rsp_tlast   // end_of_polygon
);

   typedef enum logic [3:0] {
      S_COLLECT, S_PASS_START, S_WAIT_FIRST, S_FIRST, S_NEXT, S_WAIT_CURR, S_LOAD_CURR,
      S_EVAL, S_DIV, S_MUL, S_ACC, S_WR_X, S_WR_CURR, S_ADVANCE, S_PASS_END, S_OUT
   } state_type;

   typedef enum logic [1:0] {OS_ISSUE, OS_WAIT, OS_LOAD, OS_HOLD} out_state_type;

   state_type          state_ff;
   out_state_type      ostate_ff;
   logic [PLANE_W-1:0] pass_ff;
   logic [CNT_W-1:0]   src_cnt_ff;
   logic [CNT_W-1:0]   dst_cnt_ff;
   logic [CNT_W-1:0]   edge_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [ATTR_W-1:0]  attr_ff;
   logic [OUT_W-1:0]   out_cnt_ff;
   logic [OUT_W-1:0]   out_k_ff;
   logic               do_curr_ff;
   vert_type           first_ff;
   vert_type           prev_ff;
   vert_type           curr_ff;
   vert_type           x_ff;
   logic signed [BND_W-1:0] b_prev_ff;
   logic signed [BND_W-1:0] b_curr_ff;
   logic [TQ_W-1:0]    tq_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic               rsp_tvalid_ff;
   logic               rsp_tlast_ff;
   vert_type           rsp_tdata_ff;

   vert_type           list_a_mem [MAX_LIST_VERTICES];
   vert_type           list_b_mem [MAX_LIST_VERTICES];
   vert_type           rd_a_ff;
   vert_type           rd_b_ff;
   vert_type           src_rd;

   logic               wr_a;
   logic               wr_b;
   logic [IDX_W-1:0]   wr_idx;
   vert_type           wr_data;
   logic               req_take;
   logic               dst_room;

   logic               div_start;
   logic               div_done;
   logic [TQ_W-1:0]    div_quot;
   logic signed [DIV_W-1:0] diff;
   logic signed [DIV_W-1:0] num_s;
   logic signed [DIV_W-1:0] den_s;
   logic [DIV_W-1:0]   div_num;
   logic [DIV_W-1:0]   div_den;

   logic signed [WORD_W:0]   delta;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] shifted;
   logic [WORD_W-1:0]        interp;
   logic signed [BND_W-1:0]  b_src;
   logic signed [BND_W-1:0]  b_first;
   logic                     cin;
   logic                     pin;

   assign req_take = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_COLLECT) && !reset;
   assign src_rd   = pass_ff[0] ? rd_b_ff : rd_a_ff;
   assign dst_room = (dst_cnt_ff < CNT_W'(MAX_LIST_VERTICES));
   assign b_src    = boundary(src_rd, pass_ff);
   assign b_first  = boundary(first_ff, pass_ff);
   assign cin      = !b_curr_ff[BND_W-1];
   assign pin      = !b_prev_ff[BND_W-1];

   // steer list writes: collection fills list A, passes ping-pong between the lists
   always_comb begin
      wr_a    = 1'b0;
      wr_b    = 1'b0;
      wr_idx  = dst_cnt_ff[IDX_W-1:0];
      wr_data = curr_ff;
      case (state_ff)
         S_COLLECT: begin
            wr_a    = req_take && (src_cnt_ff < CNT_W'(MAX_LIST_VERTICES));
            wr_idx  = src_cnt_ff[IDX_W-1:0];
            wr_data = vert_type'(req_tdata);
         end
         S_WR_X, S_WR_CURR: begin
            wr_a    = dst_room && pass_ff[0];
            wr_b    = dst_room && !pass_ff[0];
            wr_data = (state_ff == S_WR_X) ? x_ff : curr_ff;
         end
         default: ;
      endcase
   end

   // vertex lists, registered read
   always_ff @(posedge clock) begin
      if (wr_a) begin
         list_a_mem[wr_idx] <= wr_data;
      end
      rd_a_ff <= list_a_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         list_b_mem[wr_idx] <= wr_data;
      end
      rd_b_ff <= list_b_mem[rd_idx_ff];
   end

   // fraction numerator and denominator, made non-negative and clamped
   always_comb begin
      diff  = DIV_W'(b_prev_ff) - DIV_W'(b_curr_ff);
      num_s = DIV_W'(b_prev_ff);
      den_s = diff;
      if (diff < 0) begin
         num_s = -num_s;
         den_s = -diff;
      end
      if (num_s < 0) begin
         num_s = '0;
      end
      if (num_s > den_s) begin
         num_s = den_s;
      end
      div_num = num_s;
      div_den = den_s;
   end

   assign div_start = (state_ff == S_EVAL) && (cin != pin);

   hfc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // attribute interpolation, one attribute per multiply and accumulate pair
   always_comb begin
      delta   = $signed({curr_ff[attr_ff][WORD_W-1], curr_ff[attr_ff]})
              - $signed({prev_ff[attr_ff][WORD_W-1], prev_ff[attr_ff]});
      rounded = prod_ff + (PROD_W'(1) <<< (FRAC_BITS - 1));
      shifted = rounded >>> FRAC_BITS;
      interp  = prev_ff[attr_ff] + shifted[WORD_W-1:0];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_COLLECT;
         ostate_ff     <= OS_ISSUE;
         pass_ff       <= '0;
         src_cnt_ff    <= '0;
         dst_cnt_ff    <= '0;
         edge_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_COLLECT: begin
               if (req_take) begin
                  if (src_cnt_ff < CNT_W'(MAX_LIST_VERTICES)) begin
                     src_cnt_ff <= src_cnt_ff + 1'b1;
                  end
                  if (req_tlast) begin
                     pass_ff    <= '0;
                     dst_cnt_ff <= '0;
                     state_ff   <= S_PASS_START;
                  end
               end
            end
            S_PASS_START: begin
               rd_idx_ff <= '0;
               state_ff  <= (src_cnt_ff == '0) ? S_PASS_END : S_WAIT_FIRST;
            end
            S_WAIT_FIRST: state_ff <= S_FIRST;
            S_FIRST: begin
               first_ff  <= src_rd;
               prev_ff   <= src_rd;
               b_prev_ff <= b_src;
               edge_ff   <= '0;
               state_ff  <= S_NEXT;
            end
            S_NEXT: begin
               if (edge_ff == src_cnt_ff) begin
                  state_ff <= S_PASS_END;
               end else if (edge_ff + 1'b1 < src_cnt_ff) begin
                  rd_idx_ff <= IDX_W'(edge_ff + 1'b1);
                  state_ff  <= S_WAIT_CURR;
               end else begin
                  // closing edge back to the first vertex
                  curr_ff   <= first_ff;
                  b_curr_ff <= b_first;
                  state_ff  <= S_EVAL;
               end
            end
            S_WAIT_CURR: state_ff <= S_LOAD_CURR;
            S_LOAD_CURR: begin
               curr_ff   <= src_rd;
               b_curr_ff <= b_src;
               state_ff  <= S_EVAL;
            end
            S_EVAL: begin
               do_curr_ff <= cin;
               if (cin != pin) begin
                  state_ff <= S_DIV;
               end else if (cin) begin
                  state_ff <= S_WR_CURR;
               end else begin
                  state_ff <= S_ADVANCE;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  tq_ff    <= div_quot;
                  attr_ff  <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(delta * $signed({1'b0, tq_ff}));
               state_ff <= S_ACC;
            end
            S_ACC: begin
               x_ff[attr_ff] <= interp;
               if (attr_ff == ATTR_W'(ATTRS - 1)) begin
                  state_ff <= S_WR_X;
               end else begin
                  attr_ff  <= attr_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_WR_X: begin
               if (dst_room) begin
                  dst_cnt_ff <= dst_cnt_ff + 1'b1;
               end
               state_ff <= do_curr_ff ? S_WR_CURR : S_ADVANCE;
            end
            S_WR_CURR: begin
               if (dst_room) begin
                  dst_cnt_ff <= dst_cnt_ff + 1'b1;
               end
               state_ff <= S_ADVANCE;
            end
            S_ADVANCE: begin
               prev_ff   <= curr_ff;
               b_prev_ff <= b_curr_ff;
               edge_ff   <= edge_ff + 1'b1;
               state_ff  <= S_NEXT;
            end
            S_PASS_END: begin
               src_cnt_ff <= dst_cnt_ff;
               dst_cnt_ff <= '0;
               if (pass_ff == PLANE_W'(PLANE_COUNT - 1)) begin
                  // result now lies in list A
                  out_cnt_ff <= (dst_cnt_ff > CNT_W'(MAX_OUT)) ? OUT_W'(MAX_OUT)
                                                               : OUT_W'(dst_cnt_ff);
                  out_k_ff   <= '0;
                  ostate_ff  <= OS_ISSUE;
                  state_ff   <= S_OUT;
               end else begin
                  pass_ff  <= pass_ff + 1'b1;
                  state_ff <= S_PASS_START;
               end
            end
            S_OUT: begin
               case (ostate_ff)
                  OS_ISSUE: begin
                     if (out_k_ff == out_cnt_ff) begin
                        src_cnt_ff <= '0;
                        state_ff   <= S_COLLECT;
                     end else begin
                        rd_idx_ff <= IDX_W'(out_k_ff);
                        ostate_ff <= OS_WAIT;
                     end
                  end
                  OS_WAIT: ostate_ff <= OS_LOAD;
                  OS_LOAD: begin
                     rsp_tdata_ff  <= rd_a_ff;
                     rsp_tlast_ff  <= (out_k_ff + 1'b1 == out_cnt_ff);
                     rsp_tvalid_ff <= 1'b1;
                     ostate_ff     <= OS_HOLD;
                  end
                  OS_HOLD: begin
                     if (rsp_tready) begin
                        rsp_tvalid_ff <= 1'b0;
                        out_k_ff      <= out_k_ff + 1'b1;
                        ostate_ff     <= OS_ISSUE;
                     end
                  end
                  default: ostate_ff <= OS_ISSUE;
               endcase
            end
            default: state_ff <= S_COLLECT;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import hfc_pkg::*;

   typedef struct {
      vert_type vert;
      logic     last;
   } vertex_req_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ATTRS*WORD_W-1:0] req_tdata;   // pos_x,pos_y,pos_z,pos_w,color_r,g,b,a,tex_s,tex_t
   logic                    req_tlast;   // last_vertex
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [ATTRS*WORD_W-1:0] rsp_tdata;   // out_x,out_y,out_z,out_w,out_r,g,b,a,out_s,out_t
   logic                    rsp_tlast;   // end_of_polygon
   vert_type                rsp_vert;

   vertex_req_type pending_reqs[$];
   vertex_req_type expected_verts[$];
   vert_type    collect_list[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 0;

   homogeneous_frustum_polygon_clipper u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   assign rsp_vert = rsp_tdata;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // plane boundary w +/- coordinate, exact
   function automatic longint plane_bound(input vert_type v, input int plane);
      longint w;
      longint c;
      w = longint'($signed(v[3]));
      c = longint'($signed(v[plane / 2]));
      return (plane == 1 || plane == 2 || plane == 5) ? (w - c) : (w + c);
   endfunction

   function automatic vert_type crossing_vertex(input vert_type p1, input vert_type p2,
                                                input int plane);
      longint   b1;
      longint   num;
      longint   den;
      longint   tq;
      longint   a;
      longint   d;
      vert_type o;
      b1 = plane_bound(p1, plane);
      num = b1;
      den = b1 - plane_bound(p2, plane);
      tq = 0;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num < 0) num = 0;
      if (num > den) num = den;
      if (den != 0) tq = (num << FRAC_BITS) / den;
      for (int j = 0; j < ATTRS; j++) begin
         a = longint'($signed(p1[j]));
         d = longint'($signed(p2[j])) - a;
         o[j] = WORD_W'(a + ((d * tq + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
      end
      return o;
   endfunction

   // clip the collected polygon against all six planes, queue up to MAX_OUT surviving vertices
   task automatic predict_clip();
      vert_type src[$];
      vert_type dst[$];
      vert_type prv;
      vert_type cur;
      bit       pin;
      bit       cin;
      int       n;
      vertex_req_type e;
      src = collect_list;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         dst = {};
         n = src.size();
         for (int i = 0; i < n; i++) begin
            prv = src[i];
            cur = src[(i + 1) % n];
            pin = plane_bound(prv, p) >= 0;
            cin = plane_bound(cur, p) >= 0;
            if (cin) begin
               if (!pin && dst.size() < MAX_LIST_VERTICES)
                  dst.push_back(crossing_vertex(prv, cur, p));
               if (dst.size() < MAX_LIST_VERTICES) dst.push_back(cur);
            end else if (pin && dst.size() < MAX_LIST_VERTICES) begin
               dst.push_back(crossing_vertex(prv, cur, p));
            end
         end
         src = dst;
      end
      n = (src.size() > MAX_OUT) ? MAX_OUT : src.size();
      for (int k = 0; k < n; k++) begin
         e.vert = src[k];
         e.last = (k + 1 == n);
         expected_verts.push_back(e);
      end
      collect_list = {};
   endtask

   // drive requests; collect every accepted one and predict on the last of a polygon
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (collect_list.size() < MAX_LIST_VERTICES)
               collect_list.push_back(vert_type'(req_tdata));
            if (req_tlast) predict_clip();
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 &&
                ((cycle_count > 20000 && cycle_count < 40000) || $urandom_range(99) >= 13)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_reqs[0].vert;
               req_tlast  <= pending_reqs[0].last;
               void'(pending_reqs.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver readiness, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else if (!holdoff_done && cycle_count > 5000 && rsp_tvalid) begin
         holdoff_done <= 1;
         holdoff_left <= 3000;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= (cycle_count > 60000 && cycle_count < 80000) || $urandom_range(99) >= 13;
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verts.size() == 0) begin
            report_mismatch("unexpected result vertex");
         end else begin
            for (int j = 0; j < ATTRS; j++)
               if (rsp_vert[j] !== expected_verts[0].vert[j])
                  report_mismatch($sformatf("attr %0d got %h want %h", j,
                                  rsp_vert[j], expected_verts[0].vert[j]));
            if (rsp_tlast !== expected_verts[0].last)
               report_mismatch($sformatf("end_of_polygon got %b", rsp_tlast));
            void'(expected_verts.pop_front());
         end
      end
   end

   function automatic logic [31:0] rand_span(input int unsigned w);
      return 32'($signed({1'b0, $urandom_range(4 * w)}) - $signed({1'b0, 2 * w}));
   endfunction

   // a vertex mostly near the frustum, random attributes
   function automatic vert_type near_vertex();
      vert_type    v;
      int unsigned w;
      w = $urandom_range(32'h0010_0000, 32'h0000_1000);
      for (int j = 0; j < ATTRS; j++) v[j] = $urandom;
      v[3] = ($urandom_range(9) == 0) ? -w : w;
      for (int j = 0; j < 3; j++) v[j] = rand_span(w);
      return v;
   endfunction

   task automatic queue_req(input vert_type v, input logic last);
      vertex_req_type r;
      r.vert = v;
      r.last = last;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_polygon(input int n);
      for (int i = 0; i < n; i++) queue_req(near_vertex(), i == n - 1);
   endtask

   initial begin
      vert_type v;
      int       n;
      reset = 1'b1;
      // extremes: all ones, all zeros, most positive and negative words
      for (int i = 0; i < 3; i++) queue_req({ATTRS{32'hFFFF_FFFF}}, i == 2);
      for (int i = 0; i < 3; i++) queue_req('0, i == 2);
      queue_req({ATTRS{32'h7FFF_FFFF}}, 1'b0);
      queue_req({ATTRS{32'h8000_0000}}, 1'b0);
      queue_req({{6{32'h8000_0000}}, 32'h7FFF_FFFF, {3{32'h8000_0000}}}, 1'b1);
      // fully inside polygon with more vertices than can be returned
      for (int i = 0; i < 11; i++) begin
         v = near_vertex();
         v[3] = 32'h0001_0000;
         v[0] = 32'(i * 100); v[1] = 32'(i * 50); v[2] = 0;
         queue_req(v, i == 10);
      end
      // fully clipped: w negative everywhere
      for (int i = 0; i < 3; i++) begin
         v = near_vertex();
         v[3] = 32'hFFFF_0000; v[0] = 0; v[1] = 0; v[2] = 0;
         queue_req(v, i == 2);
      end
      // over-full input list
      queue_polygon(19);
      // random part: mostly well-formed polygons, some raw noise
      while (pending_reqs.size() < 400) begin
         if ($urandom_range(9) == 0) begin
            for (int j = 0; j < ATTRS; j++) v[j] = $urandom;
            queue_req(v, 1'($urandom_range(1)));
         end else begin
            n = ($urandom_range(15) == 0) ? $urandom_range(18, 9) : $urandom_range(8, 3);
            queue_polygon(n);
         end
      end
      queue_polygon(3);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_verts.size() == 0);
      repeat (8000) @(posedge clock);
      if (expected_verts.size() != 0) report_mismatch("expected vertices never arrived");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hfc_pkg.sv
rtl/hfc_div.sv
rtl/homogeneous_frustum_polygon_clipper.sv
verif/testbench.sv
